// ----- rtl/i2p_pkg.sv -----
`timescale 1ns / 1ps
// i2p_pkg: shared constants, types and decode functions of the infix to postfix converter
// no dependencies; used by i2p_cell, i2p_stack and infix_to_postfix_converter
package i2p_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int CODE_W      = 3;

   // ascii characters
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // stacked operator codes
   localparam logic [CODE_W-1:0] OP_OPEN = 3'd0;
   localparam logic [CODE_W-1:0] OP_ADD  = 3'd1;
   localparam logic [CODE_W-1:0] OP_SUB  = 3'd2;
   localparam logic [CODE_W-1:0] OP_MUL  = 3'd3;
   localparam logic [CODE_W-1:0] OP_DIV  = 3'd4;

   // error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_FULL      = 2'd1;
   localparam logic [1:0] ERR_UNMATCHED = 2'd2;

   typedef struct packed {
      logic              push;
      logic              pop;
      logic [CODE_W-1:0] code;
   } stk_cmd_type;

   typedef struct packed {
      logic              empty;
      logic              full;
      logic [CODE_W-1:0] top;
   } stk_stat_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_operator(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
   endfunction

   function automatic logic [CODE_W-1:0] op_code(input logic [7:0] c);
      logic [CODE_W-1:0] r;
      unique case (c)
         CH_PLUS:  r = OP_ADD;
         CH_MINUS: r = OP_SUB;
         CH_STAR:  r = OP_MUL;
         CH_SLASH: r = OP_DIV;
         default:  r = OP_OPEN;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] code_prec(input logic [CODE_W-1:0] c);
      logic [1:0] r;
      unique case (c)
         OP_ADD, OP_SUB: r = 2'd2;
         OP_MUL, OP_DIV: r = 2'd3;
         default:        r = 2'd1;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] code_char(input logic [CODE_W-1:0] c);
      logic [7:0] r;
      unique case (c)
         OP_ADD:  r = CH_PLUS;
         OP_SUB:  r = CH_MINUS;
         OP_MUL:  r = CH_STAR;
         OP_DIV:  r = CH_SLASH;
         default: r = CH_OPEN;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/i2p_cell.sv -----
`timescale 1ns / 1ps
// i2p_cell: one entry of the shifting operator stack
// depends on i2p_pkg
module i2p_cell (
   input  logic                        clock,
   input  i2p_pkg::stk_cmd_type        cmd,
   input  logic [i2p_pkg::CODE_W-1:0]  upper_code,
   input  logic [i2p_pkg::CODE_W-1:0]  lower_code,
   output logic [i2p_pkg::CODE_W-1:0]  code
);
   import i2p_pkg::*;

   logic [CODE_W-1:0] code_ff;

   // push moves every entry one place down, pop one place up
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         code_ff <= upper_code;
      end else if (cmd.pop) begin
         code_ff <= lower_code;
      end
   end

   assign code = code_ff;

endmodule

// ----- rtl/i2p_stack.sv -----
`timescale 1ns / 1ps
// i2p_stack: operator stack built as a row of i2p_cell entries, top in cell 0
// depends on i2p_pkg and i2p_cell
module i2p_stack (
   input  logic                  clock,
   input  logic                  reset,
   input  i2p_pkg::stk_cmd_type  cmd,
   output i2p_pkg::stk_stat_type stat
);
   import i2p_pkg::*;

   logic [CODE_W-1:0] code_w [STACK_DEPTH];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [CODE_W-1:0] upper_w;
      logic [CODE_W-1:0] lower_w;
      if (i == 0) begin : g_first
         assign upper_w = cmd.code;
      end else begin : g_mid_up
         assign upper_w = code_w[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_last
         assign lower_w = code_w[i];
      end else begin : g_mid_down
         assign lower_w = code_w[i+1];
      end
      i2p_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .upper_code (upper_w),
         .lower_code (lower_w),
         .code       (code_w[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_W'(STACK_DEPTH));
   assign stat.top   = code_w[0];

   ap_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !stat.full)
      else $error("push into a full stack");

   ap_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !stat.empty)
      else $error("pop from an empty stack");

   ap_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

endmodule

// ----- rtl/infix_to_postfix_converter.sv -----
`timescale 1ns / 1ps
// infix_to_postfix_converter: shunting-yard sequencer around a shifting operator stack
// a digit, point or unary minus result passes through the hold slot, then the output register
// a new input beat is taken only back in S_IDLE; an operator or ')' adds a step per operator
// popped, and end of expression one per stacked entry flushed; a stalled output holds the sequencer
// reset: synchronous, active high; empties the stack and restarts at the start of an expression
// depends on i2p_pkg and i2p_stack
module infix_to_postfix_converter (
   input  logic        clock,
   input  logic        reset,
   // input beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] ch, [15:8] next_ch
   input  logic        req_tlast,   // end_of_expr
   // result beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] symbol, [8] space_after, [10:9] error, rest zero
   output logic        rsp_tlast    // last result of the input beat
);
   import i2p_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_OPLOOP   = 3'd2;
   localparam logic [2:0] S_CLOSE    = 3'd3;
   localparam logic [2:0] S_FLUSH    = 3'd4;
   localparam logic [2:0] S_FINISH   = 3'd5;

   logic [2:0]   state_ff, state_in;
   logic [7:0]   ch_ff, nx_ff;
   logic         eoe_ff;
   logic [1:0]   err_ff, err_in;
   logic [7:0]   prev_ff, prev_in;
   logic         at_start_ff, at_start_in;

   // hold slot: keeps the newest result until we know whether it is the last one
   logic         hold_valid_ff, hold_valid_in;
   logic [7:0]   hold_sym_ff;
   logic         hold_space_ff;
   logic [1:0]   hold_err_ff;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_sym_ff;
   logic         rsp_space_ff;
   logic [1:0]   rsp_err_ff;
   logic         rsp_last_ff;

   logic         req_accept;
   logic         out_free;
   logic         adv;
   logic         move_out;
   logic         emit;
   logic [7:0]   emit_sym;
   logic         emit_space;
   logic [1:0]   emit_err;
   logic         finish;

   stk_cmd_type  cmd;
   stk_stat_type stat;

   i2p_stack u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   // the sequencer only steps when a new result has somewhere to go
   assign adv        = !hold_valid_ff || out_free;
   assign move_out   = hold_valid_ff && (emit || finish);

   always_comb begin
      state_in    = state_ff;
      err_in      = err_ff;
      prev_in     = prev_ff;
      at_start_in = at_start_ff;
      emit        = 1'b0;
      emit_sym    = '0;
      emit_space  = 1'b0;
      emit_err    = ERR_NONE;
      finish      = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (adv) begin
               state_in = S_FLUSH;
               if (at_start_ff && ch_ff == CH_MINUS) begin
                  // leading unary minus
                  emit     = 1'b1;
                  emit_sym = CH_HASH;
               end else if (is_digit(ch_ff) && !is_digit(nx_ff) && nx_ff != CH_DOT) begin
                  // last digit of a number
                  emit       = 1'b1;
                  emit_sym   = ch_ff;
                  emit_space = 1'b1;
               end else if ((is_digit(ch_ff) && (is_digit(nx_ff) || nx_ff == CH_DOT))
                            || ch_ff == CH_DOT) begin
                  emit     = 1'b1;
                  emit_sym = ch_ff;
               end else if (prev_ff == CH_OPEN && ch_ff == CH_MINUS) begin
                  // unary minus right after an open parenthesis
                  emit     = 1'b1;
                  emit_sym = CH_HASH;
               end else if (is_operator(ch_ff) && prev_ff != CH_OPEN) begin
                  state_in = S_OPLOOP;
               end else if (ch_ff == CH_OPEN) begin
                  if (stat.full) begin
                     err_in = ERR_FULL;
                  end else begin
                     cmd.push = 1'b1;
                     cmd.code = OP_OPEN;
                  end
               end else if (ch_ff == CH_CLOSE) begin
                  state_in = S_CLOSE;
               end
            end
         end
         S_OPLOOP: begin
            if (adv) begin
               if (!stat.empty && code_prec(stat.top) >= code_prec(op_code(ch_ff))) begin
                  cmd.pop    = 1'b1;
                  emit       = 1'b1;
                  emit_sym   = code_char(stat.top);
                  emit_space = 1'b1;
               end else begin
                  if (stat.full) begin
                     err_in = ERR_FULL;
                  end else begin
                     cmd.push = 1'b1;
                     cmd.code = op_code(ch_ff);
                  end
                  state_in = S_FLUSH;
               end
            end
         end
         S_CLOSE: begin
            if (adv) begin
               if (stat.empty) begin
                  err_in   = ERR_UNMATCHED;
                  state_in = S_FLUSH;
               end else if (stat.top == OP_OPEN) begin
                  // matching open parenthesis is dropped silently
                  cmd.pop  = 1'b1;
                  state_in = S_FLUSH;
               end else begin
                  cmd.pop    = 1'b1;
                  emit       = 1'b1;
                  emit_sym   = code_char(stat.top);
                  emit_space = 1'b1;
               end
            end
         end
         S_FLUSH: begin
            if (adv) begin
               if (eoe_ff && !stat.empty) begin
                  // end of expression drains the stack, leftover open included
                  cmd.pop    = 1'b1;
                  emit       = 1'b1;
                  emit_sym   = code_char(stat.top);
                  emit_space = 1'b1;
               end else begin
                  if (eoe_ff) begin
                     prev_in     = '0;
                     at_start_in = 1'b1;
                  end else begin
                     prev_in     = ch_ff;
                     at_start_in = 1'b0;
                  end
                  // error result goes after every symbol of the beat
                  if (err_ff != ERR_NONE) begin
                     emit     = 1'b1;
                     emit_err = err_ff;
                     err_in   = ERR_NONE;
                  end
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (adv) begin
               finish   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (emit) begin
         hold_valid_in = 1'b1;
      end else if (finish) begin
         hold_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (move_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         err_ff        <= ERR_NONE;
         prev_ff       <= '0;
         at_start_ff   <= 1'b1;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         err_ff        <= err_in;
         prev_ff       <= prev_in;
         at_start_ff   <= at_start_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         ch_ff  <= req_tdata[7:0];
         nx_ff  <= req_tdata[15:8];
         eoe_ff <= req_tlast;
      end
      if (emit) begin
         hold_sym_ff   <= emit_sym;
         hold_space_ff <= emit_space;
         hold_err_ff   <= emit_err;
      end
      if (move_out) begin
         rsp_sym_ff   <= hold_sym_ff;
         rsp_space_ff <= hold_space_ff;
         rsp_err_ff   <= hold_err_ff;
         rsp_last_ff  <= finish;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_err_ff, rsp_space_ff, rsp_sym_ff};
   assign rsp_tlast  = rsp_last_ff;

   ap_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !hold_valid_ff)
      else $error("result of the previous beat still held while idle");

   ap_error_beat_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff != ERR_NONE) |-> (rsp_sym_ff == '0 && !rsp_space_ff))
      else $error("error result carries a symbol");

   ap_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_DISPATCH))
      else $error("accepted beat not dispatched");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for infix_to_postfix_converter, with a scoreboard that predicts
// each postfix beat from the characters fed in; depends on i2p_pkg and the converter rtl
module tb;
   import i2p_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_CHARS = 320;
   localparam int HOLD_CYCLES  = 300;   // long receiver stall so the converter backs up
   localparam int HOLD_AT      = 80;    // result count at which that stall starts
   localparam int DRAIN_CYCLES = 40;

   // one expected result beat
   typedef struct packed {
      logic [7:0] symbol;
      logic       space_after;
      logic [1:0] error;
      logic       last;
   } symbol_beat_type;

   // shunting-yard predictor plus the queue of symbols it still owes
   class postfix_scoreboard;
      symbol_beat_type   expected_symbols[$];
      logic [CODE_W-1:0] op_stack[STACK_DEPTH];
      int unsigned       op_depth;
      logic [7:0]        prev_ch;
      bit                expr_start;
      int                step_emits;
      int                mismatches;
      int                symbols_checked;
      int                full_reports;
      int                unmatched_reports;

      function new();
         op_depth          = 0;
         prev_ch           = 8'd0;
         expr_start        = 1'b1;
         mismatches        = 0;
         symbols_checked   = 0;
         full_reports      = 0;
         unmatched_reports = 0;
      endfunction

      function bit is_num(input logic [7:0] c);
         return c >= CH_ZERO && c <= CH_NINE;
      endfunction

      function bit decode_op(input logic [7:0] c, output logic [CODE_W-1:0] code);
         code = OP_OPEN;
         case (c)
            CH_PLUS:  code = OP_ADD;
            CH_MINUS: code = OP_SUB;
            CH_STAR:  code = OP_MUL;
            CH_SLASH: code = OP_DIV;
            default:  return 1'b0;
         endcase
         return 1'b1;
      endfunction

      function int rank(input logic [CODE_W-1:0] code);
         if (code == OP_MUL || code == OP_DIV) return 3;
         if (code == OP_ADD || code == OP_SUB) return 2;
         return 1;
      endfunction

      function logic [7:0] glyph(input logic [CODE_W-1:0] code);
         case (code)
            OP_ADD:  return CH_PLUS;
            OP_SUB:  return CH_MINUS;
            OP_MUL:  return CH_STAR;
            OP_DIV:  return CH_SLASH;
            default: return CH_OPEN;
         endcase
      endfunction

      function void emit(input logic [7:0] sym, input logic sp, input logic [1:0] err);
         symbol_beat_type b;
         b.symbol      = sym;
         b.space_after = sp;
         b.error       = err;
         b.last        = 1'b0;
         expected_symbols.push_back(b);
         step_emits++;
      endfunction

      function void pop_emit();
         op_depth--;
         emit(glyph(op_stack[op_depth]), 1'b1, ERR_NONE);
      endfunction

      function bit push_op(input logic [CODE_W-1:0] code);
         if (op_depth >= STACK_DEPTH) return 1'b0;
         op_stack[op_depth] = code;
         op_depth++;
         return 1'b1;
      endfunction

      // one accepted input beat: work out every symbol it owes
      function void take_char(input logic [7:0] ch, input logic [7:0] nx, input logic eoe);
         logic [1:0]        err;
         logic [CODE_W-1:0] code;
         bit                is_op;
         bit                found;
         err        = ERR_NONE;
         step_emits = 0;
         is_op      = decode_op(ch, code);
         if (expr_start && ch == CH_MINUS) begin
            emit(CH_HASH, 1'b0, ERR_NONE);
         end else if (is_num(ch) && !is_num(nx) && nx != CH_DOT) begin
            emit(ch, 1'b1, ERR_NONE);
         end else if ((is_num(ch) && (is_num(nx) || nx == CH_DOT)) || ch == CH_DOT) begin
            emit(ch, 1'b0, ERR_NONE);
         end else if (prev_ch == CH_OPEN && ch == CH_MINUS) begin
            emit(CH_HASH, 1'b0, ERR_NONE);
         end else if (is_op && prev_ch != CH_OPEN) begin
            while (op_depth > 0 && rank(op_stack[op_depth-1]) >= rank(code))
               pop_emit();
            if (!push_op(code)) err = ERR_FULL;
         end else if (ch == CH_OPEN) begin
            if (!push_op(OP_OPEN)) err = ERR_FULL;
         end else if (ch == CH_CLOSE) begin
            found = 1'b0;
            while (op_depth > 0 && !found) begin
               if (op_stack[op_depth-1] == OP_OPEN) begin
                  op_depth--;
                  found = 1'b1;
               end else begin
                  pop_emit();
               end
            end
            if (!found) err = ERR_UNMATCHED;
         end
         if (eoe) begin
            while (op_depth > 0) pop_emit();
            prev_ch    = 8'd0;
            expr_start = 1'b1;
         end else begin
            prev_ch    = ch;
            expr_start = 1'b0;
         end
         if (err != ERR_NONE) emit(8'd0, 1'b0, err);
         if (step_emits > 0) expected_symbols[expected_symbols.size()-1].last = 1'b1;
      endfunction

      // one accepted result beat against the oldest expectation
      function void check_symbol(input logic [15:0] data, input logic last);
         symbol_beat_type want;
         if (expected_symbols.size() == 0) begin
            $error("unexpected result beat: tdata %h tlast %b", data, last);
            mismatches++;
            return;
         end
         want = expected_symbols.pop_front();
         symbols_checked++;
         if (want.error == ERR_FULL) full_reports++;
         if (want.error == ERR_UNMATCHED) unmatched_reports++;
         if (data[7:0] !== want.symbol) begin
            $error("symbol: expected %h, got %h", want.symbol, data[7:0]);
            mismatches++;
         end
         if (data[8] !== want.space_after) begin
            $error("space_after: expected %b, got %b", want.space_after, data[8]);
            mismatches++;
         end
         if (data[10:9] !== want.error) begin
            $error("error: expected %0d, got %0d", want.error, data[10:9]);
            mismatches++;
         end
         if (data[15:11] !== 5'd0) begin
            $error("tdata padding: expected 0, got %h", data[15:11]);
            mismatches++;
         end
         if (last !== want.last) begin
            $error("last: expected %b, got %b", want.last, last);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = 16'd0;   // [7:0] ch, [15:8] next_ch
   logic        req_tlast  = 1'b0;    // end_of_expr
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [7:0] symbol, [8] space_after, [10:9] error
   logic        rsp_tlast;            // last result of the input beat

   postfix_scoreboard sb = new();
   int cycle_count  = 0;
   int items_sent   = 0;
   int random_items = 0;
   int req_quiet    = 0;
   int rsp_quiet    = 0;

   infix_to_postfix_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // per-beat idle draw: mostly a random gap before the beat, now and then a run of back-to-back beats
   function automatic int draw_gap(ref int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         quiet_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   // offer one character beat; valid stays high into the next beat when no gap is drawn
   task automatic send_char(input logic [7:0] ch, input logic [7:0] nx, input logic eoe);
      int gap;
      gap = draw_gap(req_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {nx, ch};
      req_tlast  <= eoe;
      do @(posedge clock); while (!req_tready);
      sb.take_char(ch, nx, eoe);
      items_sent++;
   endtask

   // a character run, each beat carrying its successor, tlast on the final one if asked
   task automatic send_string(ref logic [7:0] q[$], input bit mark_end);
      for (int i = 0; i < q.size(); i++)
         send_char(q[i], (i + 1 < q.size()) ? q[i+1] : 8'd0, mark_end && i == q.size() - 1);
   endtask

   task automatic send_text(input string s, input bit mark_end);
      logic [7:0] q[$];
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      send_string(q, mark_end);
   endtask

   // sender goes quiet until every owed result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.expected_symbols.size() != 0) @(posedge clock);
   endtask

   // expression builders
   function automatic logic [7:0] pick_op();
      case ($urandom_range(0, 3))
         0:       return CH_PLUS;
         1:       return CH_MINUS;
         2:       return CH_STAR;
         default: return CH_SLASH;
      endcase
   endfunction

   function automatic void add_number(ref logic [7:0] q[$]);
      repeat ($urandom_range(1, 3)) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 3) == 0) begin
         q.push_back(CH_DOT);
         repeat ($urandom_range(1, 2)) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
   endfunction

   function automatic void add_operand(ref logic [7:0] q[$], input int depth);
      if (depth < 4 && $urandom_range(0, 3) == 0) begin
         q.push_back(CH_OPEN);
         if ($urandom_range(0, 2) == 0) q.push_back(CH_MINUS);
         add_expr(q, depth + 1);
         q.push_back(CH_CLOSE);
      end else begin
         add_number(q);
      end
   endfunction

   function automatic void add_expr(ref logic [7:0] q[$], input int depth);
      add_operand(q, depth);
      repeat ($urandom_range(0, 3)) begin
         q.push_back(pick_op());
         add_operand(q, depth);
      end
   endfunction

   function automatic void build_expr(ref logic [7:0] q[$]);
      q.delete();
      if ($urandom_range(0, 3) == 0) q.push_back(CH_MINUS);
      add_expr(q, 0);
   endfunction

   // parentheses nested to the given depth; a large depth reaches, and passes, the stack limit
   function automatic void build_nest(ref logic [7:0] q[$], input int levels);
      q.delete();
      repeat (levels) begin
         if ($urandom_range(0, 1) == 0) begin
            add_number(q);
            q.push_back(pick_op());
         end
         q.push_back(CH_OPEN);
      end
      add_number(q);
      repeat (levels + $urandom_range(0, 1)) q.push_back(CH_CLOSE);
   endfunction

   // one broken edit: replace, drop or insert a character
   function automatic void mangle(ref logic [7:0] q[$]);
      int         pos;
      logic [7:0] c;
      pos = $urandom_range(0, q.size() - 1);
      case ($urandom_range(0, 5))
         0:       c = CH_OPEN;
         1:       c = CH_CLOSE;
         2:       c = pick_op();
         3:       c = CH_DOT;
         4:       c = 8'h20;
         default: c = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 2))
         0:       q[pos] = c;
         1:       if (q.size() > 1) q.delete(pos);
         default: q.insert(pos, c);
      endcase
   endfunction

   // reset, then stimulus, then the final verdict
   initial begin
      logic [7:0] q[$];
      int         sel;
      bit         paused_mid;
      paused_mid = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: unary minus at start and after open, all four operators with
      // precedence pops, a decimal point, an operator right after open,
      // a leftover open at the flush, an unmatched close, and byte extremes
      send_text("-12.5*(-3+4)/2-7", 1'b1);
      send_text("((+1)", 1'b1);
      send_text("9)", 1'b1);
      send_char(8'h00, 8'h00, 1'b0);
      send_char(8'hFF, 8'hFF, 1'b1);
      wait_drained();

      // first random run overflows the stack for sure
      build_nest(q, 34);
      send_string(q, 1'b1);
      random_items += q.size();

      while (random_items < RANDOM_CHARS) begin
         sel = $urandom_range(0, 99);
         if (sel < 65) begin
            build_expr(q);
            send_string(q, 1'b1);
            random_items += q.size();
         end else if (sel < 75) begin
            build_expr(q);
            repeat ($urandom_range(1, 2)) mangle(q);
            send_string(q, 1'b1);
            random_items += q.size();
         end else if (sel < 80) begin
            // runs on into the next expression without an end mark
            build_expr(q);
            send_string(q, 1'b0);
            random_items += q.size();
         end else if (sel < 90) begin
            repeat ($urandom_range(1, 4))
               send_char(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
         end else if (sel < 94) begin
            build_nest(q, $urandom_range(20, 36));
            send_string(q, 1'b1);
            random_items += q.size();
         end else begin
            // stray closes in an otherwise valid expression
            build_expr(q);
            q.push_back(CH_CLOSE);
            q.push_back(pick_op());
            add_number(q);
            q.push_back(CH_CLOSE);
            send_string(q, 1'b1);
            random_items += q.size();
         end
         if (!paused_mid && random_items >= RANDOM_CHARS / 2) begin
            paused_mid = 1'b1;
            wait_drained();
         end
      end
      req_tvalid <= 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d input beats, %0d of them expression characters",
               items_sent, random_items);
      $display("%0d result beats checked, %0d stack-full and %0d unmatched-close reports",
               sb.symbols_checked, sb.full_reports, sb.unmatched_reports);
      if (sb.mismatches == 0 && sb.expected_symbols.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // result side: random stalls, one long hold-off once results are flowing
   initial begin
      int gap;
      int results_seen;
      results_seen = 0;
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(rsp_quiet);
         if (results_seen == HOLD_AT) gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         sb.check_symbol(rsp_tdata, rsp_tlast);
         results_seen++;
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
